// File: rtl/core/dcq_pkg.sv
// Shared types, codes and defaults for the deferred call queue.
`timescale 1ns / 1ps
package dcq_pkg;

    localparam int DEF_HIGH_DEPTH = 16;
    localparam int DEF_LOW_DEPTH  = 16;
    localparam int WORD_W         = 32;

    localparam logic OP_POST  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] PRI_HIGH = 2'd0;
    localparam logic [1:0] PRI_LOW  = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        KIND_DRAIN,
        KIND_POST,
        KIND_BAD_PRI,
        KIND_NULL_HANDLE
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               pri;
        logic [WORD_W-1:0]  handle;
        logic [WORD_W-1:0]  argument;
    } cmd_t;

endpackage

// File: rtl/core/dcq_front.sv
// Front end: takes items and classifies them into queue commands.
`timescale 1ns / 1ps
module dcq_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [1:0]                   pri,
    input  logic [dcq_pkg::WORD_W-1:0]   handle,
    input  logic [dcq_pkg::WORD_W-1:0]   argument,
    input  logic                         fifo_full,
    output logic                         push,
    output dcq_pkg::cmd_t                cmd
);

    logic           valid_reg;
    logic           valid_next;
    dcq_pkg::cmd_t  cmd_reg;
    dcq_pkg::cmd_t  cmd_next;
    logic           accept;

    assign busy   = valid_reg && fifo_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !fifo_full;
    assign cmd    = cmd_reg;

    always_comb
    begin
        cmd_next.pri      = pri[0];
        cmd_next.handle   = handle;
        cmd_next.argument = argument;
        if (op == dcq_pkg::OP_DRAIN)
        begin
            cmd_next.kind = dcq_pkg::KIND_DRAIN;
        end
        else if (pri != dcq_pkg::PRI_HIGH && pri != dcq_pkg::PRI_LOW)
        begin
            cmd_next.kind = dcq_pkg::KIND_BAD_PRI;
        end
        else if (handle == '0)
        begin
            cmd_next.kind = dcq_pkg::KIND_NULL_HANDLE;
        end
        else
        begin
            cmd_next.kind = dcq_pkg::KIND_POST;
        end

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: rtl/core/dcq_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module dcq_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dcq_pkg::cmd_t  din,
    input  logic           pop,
    output dcq_pkg::cmd_t  dout,
    output logic           full,
    output logic           empty
);

    dcq_pkg::cmd_t  slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/core/dcq_back.sv
// Back end: the two ring stores, their metrics, and command execution.
`timescale 1ns / 1ps
module dcq_back
#(
    parameter int HIGH_DEPTH = dcq_pkg::DEF_HIGH_DEPTH,
    parameter int LOW_DEPTH  = dcq_pkg::DEF_LOW_DEPTH,
    parameter int PW         = $clog2(((HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH) + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  dcq_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         strobe,
    output logic [1:0]                   status,
    output logic                         entry_valid,
    output logic                         entry_pri,
    output logic [dcq_pkg::WORD_W-1:0]   entry_handle,
    output logic [dcq_pkg::WORD_W-1:0]   entry_argument,
    output logic [PW-1:0]                peak_fill,
    output logic [dcq_pkg::WORD_W-1:0]   drop_total,
    output logic                         last
);

    localparam int HAW  = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
    localparam int LAW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
    localparam int HFW  = $clog2(HIGH_DEPTH + 1);
    localparam int LFW  = $clog2(LOW_DEPTH + 1);
    localparam int W    = dcq_pkg::WORD_W;
    localparam int EW   = 2 * W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN_HIGH,
        S_DRAIN_LOW
    } state_t;

    logic [EW-1:0]  high_mem [HIGH_DEPTH];
    logic [EW-1:0]  low_mem  [LOW_DEPTH];
    logic [EW-1:0]  high_rd_reg;
    logic [EW-1:0]  low_rd_reg;
    logic           high_we;
    logic           low_we;

    state_t         state_reg, state_next;
    logic [HAW-1:0] high_head_reg, high_head_next, high_tail_reg, high_tail_next;
    logic [LAW-1:0] low_head_reg, low_head_next, low_tail_reg, low_tail_next;
    logic [HFW-1:0] high_fill_reg, high_fill_next, high_peak_reg, high_peak_next;
    logic [LFW-1:0] low_fill_reg, low_fill_next, low_peak_reg, low_peak_next;
    logic [W-1:0]   high_drops_reg, high_drops_next, low_drops_reg, low_drops_next;

    logic           strobe_reg, strobe_next;
    logic [1:0]     status_reg, status_next;
    logic           entry_valid_reg, entry_valid_next;
    logic           pri_reg, pri_next;
    logic [PW-1:0]  peak_reg, peak_next;
    logic [W-1:0]   drops_reg, drops_next;
    logic           last_reg, last_next;

    logic [HFW-1:0] high_fill_inc;
    logic [LFW-1:0] low_fill_inc;
    logic [EW-1:0]  rd_sel;

    assign high_fill_inc = high_fill_reg + HFW'(1);
    assign low_fill_inc  = low_fill_reg + LFW'(1);
    assign cmd_pop       = cmd_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        high_head_next   = high_head_reg;
        high_tail_next   = high_tail_reg;
        high_fill_next   = high_fill_reg;
        high_peak_next   = high_peak_reg;
        high_drops_next  = high_drops_reg;
        low_head_next    = low_head_reg;
        low_tail_next    = low_tail_reg;
        low_fill_next    = low_fill_reg;
        low_peak_next    = low_peak_reg;
        low_drops_next   = low_drops_reg;
        high_we          = 1'b0;
        low_we           = 1'b0;
        strobe_next      = 1'b0;
        status_next      = dcq_pkg::ST_OK;
        entry_valid_next = 1'b0;
        pri_next         = 1'b0;
        peak_next        = '0;
        drops_next       = '0;
        last_next        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        dcq_pkg::KIND_DRAIN:
                        begin
                            if (high_fill_reg != '0)
                            begin
                                state_next = S_DRAIN_HIGH;
                            end
                            else if (low_fill_reg != '0)
                            begin
                                state_next = S_DRAIN_LOW;
                            end
                            else
                            begin
                                // nothing stored: single result with zero payload, peak and drop count, marked last
                                strobe_next = 1'b1;
                            end
                        end
                        dcq_pkg::KIND_BAD_PRI:
                        begin
                            strobe_next = 1'b1;
                            status_next = dcq_pkg::ST_INVALID;
                        end
                        dcq_pkg::KIND_NULL_HANDLE:
                        begin
                            strobe_next = 1'b1;
                            status_next = dcq_pkg::ST_INVALID;
                            pri_next    = cmd.pri;
                            peak_next   = cmd.pri ? PW'(low_peak_reg) : PW'(high_peak_reg);
                            drops_next  = cmd.pri ? low_drops_reg : high_drops_reg;
                        end
                        dcq_pkg::KIND_POST:
                        begin
                            strobe_next = 1'b1;
                            pri_next    = cmd.pri;
                            if (!cmd.pri)
                            begin
                                if (high_fill_reg == HFW'(HIGH_DEPTH))
                                begin
                                    high_drops_next = high_drops_reg + W'(1);
                                    status_next     = dcq_pkg::ST_FULL;
                                end
                                else
                                begin
                                    high_we        = 1'b1;
                                    high_fill_next = high_fill_inc;
                                    high_head_next = (high_head_reg == HAW'(HIGH_DEPTH - 1)) ?
                                                     '0 : high_head_reg + HAW'(1);
                                    if (high_fill_inc > high_peak_reg)
                                    begin
                                        high_peak_next = high_fill_inc;
                                    end
                                end
                                peak_next  = PW'(high_peak_next);
                                drops_next = high_drops_next;
                            end
                            else
                            begin
                                if (low_fill_reg == LFW'(LOW_DEPTH))
                                begin
                                    low_drops_next = low_drops_reg + W'(1);
                                    status_next    = dcq_pkg::ST_FULL;
                                end
                                else
                                begin
                                    low_we        = 1'b1;
                                    low_fill_next = low_fill_inc;
                                    low_head_next = (low_head_reg == LAW'(LOW_DEPTH - 1)) ?
                                                    '0 : low_head_reg + LAW'(1);
                                    if (low_fill_inc > low_peak_reg)
                                    begin
                                        low_peak_next = low_fill_inc;
                                    end
                                end
                                peak_next  = PW'(low_peak_next);
                                drops_next = low_drops_next;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_DRAIN_HIGH:
            begin
                // read issued at the tail; data shows up with the result next cycle
                strobe_next      = 1'b1;
                entry_valid_next = 1'b1;
                peak_next        = PW'(high_peak_reg);
                drops_next       = high_drops_reg;
                high_fill_next   = high_fill_reg - HFW'(1);
                high_tail_next   = (high_tail_reg == HAW'(HIGH_DEPTH - 1)) ?
                                   '0 : high_tail_reg + HAW'(1);
                last_next        = (high_fill_reg == HFW'(1)) && (low_fill_reg == '0);
                if (high_fill_reg == HFW'(1))
                begin
                    state_next = (low_fill_reg != '0) ? S_DRAIN_LOW : S_IDLE;
                end
            end
            S_DRAIN_LOW:
            begin
                strobe_next      = 1'b1;
                entry_valid_next = 1'b1;
                pri_next         = 1'b1;
                peak_next        = PW'(low_peak_reg);
                drops_next       = low_drops_reg;
                low_fill_next    = low_fill_reg - LFW'(1);
                low_tail_next    = (low_tail_reg == LAW'(LOW_DEPTH - 1)) ?
                                   '0 : low_tail_reg + LAW'(1);
                last_next        = low_fill_reg == LFW'(1);
                if (low_fill_reg == LFW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            high_head_reg   <= '0;
            high_tail_reg   <= '0;
            high_fill_reg   <= '0;
            high_peak_reg   <= '0;
            high_drops_reg  <= '0;
            low_head_reg    <= '0;
            low_tail_reg    <= '0;
            low_fill_reg    <= '0;
            low_peak_reg    <= '0;
            low_drops_reg   <= '0;
            strobe_reg      <= 1'b0;
            status_reg      <= dcq_pkg::ST_OK;
            entry_valid_reg <= 1'b0;
            pri_reg         <= 1'b0;
            peak_reg        <= '0;
            drops_reg       <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            high_head_reg   <= high_head_next;
            high_tail_reg   <= high_tail_next;
            high_fill_reg   <= high_fill_next;
            high_peak_reg   <= high_peak_next;
            high_drops_reg  <= high_drops_next;
            low_head_reg    <= low_head_next;
            low_tail_reg    <= low_tail_next;
            low_fill_reg    <= low_fill_next;
            low_peak_reg    <= low_peak_next;
            low_drops_reg   <= low_drops_next;
            strobe_reg      <= strobe_next;
            status_reg      <= status_next;
            entry_valid_reg <= entry_valid_next;
            pri_reg         <= pri_next;
            peak_reg        <= peak_next;
            drops_reg       <= drops_next;
            last_reg        <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (high_we)
        begin
            high_mem[high_head_reg] <= {cmd.handle, cmd.argument};
        end
        high_rd_reg <= high_mem[high_tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (low_we)
        begin
            low_mem[low_head_reg] <= {cmd.handle, cmd.argument};
        end
        low_rd_reg <= low_mem[low_tail_reg];
    end

    assign rd_sel         = pri_reg ? low_rd_reg : high_rd_reg;
    assign strobe         = strobe_reg;
    assign status         = status_reg;
    assign entry_valid    = entry_valid_reg;
    assign entry_pri      = pri_reg;
    assign entry_handle   = entry_valid_reg ? rd_sel[EW-1:W] : '0;
    assign entry_argument = entry_valid_reg ? rd_sel[W-1:0] : '0;
    assign peak_fill      = peak_reg;
    assign drop_total     = drops_reg;
    assign last           = last_reg;

endmodule

// File: rtl/core/two_priority_deferred_call_queue_core.sv
// A post or empty-drain result passes the front register, the command queue and the result
// registers; drained entries then follow, one entry per cycle, from the back end's store read port.
// Throughput: one post per cycle while busy is low; a drain holds the back end until every stored entry is read out.
// Reset clears pointers, fill levels, peaks, drop counters and the command queue;
// store contents are not cleared and no clearing pass runs. Results cannot be stalled.
// busy rises only when the front register and the two-entry command queue are all full.
`timescale 1ns / 1ps
module two_priority_deferred_call_queue_core
#(
    parameter int HIGH_DEPTH = dcq_pkg::DEF_HIGH_DEPTH,
    parameter int LOW_DEPTH  = dcq_pkg::DEF_LOW_DEPTH,
    parameter int PW         = $clog2(((HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH) + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [1:0]                   pri,
    input  logic [dcq_pkg::WORD_W-1:0]   handle,
    input  logic [dcq_pkg::WORD_W-1:0]   argument,
    output logic                         strobe,
    output logic [1:0]                   status,
    output logic                         entry_valid,
    output logic                         entry_pri,
    output logic [dcq_pkg::WORD_W-1:0]   entry_handle,
    output logic [dcq_pkg::WORD_W-1:0]   entry_argument,
    output logic [PW-1:0]                peak_fill,
    output logic [dcq_pkg::WORD_W-1:0]   drop_total,
    output logic                         last
);

    dcq_pkg::cmd_t  front_cmd;
    dcq_pkg::cmd_t  queue_cmd;
    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;

    dcq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .pri       (pri),
        .handle    (handle),
        .argument  (argument),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (front_cmd)
    );

    dcq_cmd_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .pop   (pop),
        .dout  (queue_cmd),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    dcq_back
    #(
        .HIGH_DEPTH (HIGH_DEPTH),
        .LOW_DEPTH  (LOW_DEPTH),
        .PW         (PW)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (!fifo_empty),
        .cmd            (queue_cmd),
        .cmd_pop        (pop),
        .strobe         (strobe),
        .status         (status),
        .entry_valid    (entry_valid),
        .entry_pri      (entry_pri),
        .entry_handle   (entry_handle),
        .entry_argument (entry_argument),
        .peak_fill      (peak_fill),
        .drop_total     (drop_total),
        .last           (last)
    );

    // results without an entry always end their item
    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !entry_valid |-> last)
        else $error("non-entry result without last");

    // drained entries only ever report ok
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && entry_valid |-> status == dcq_pkg::ST_OK)
        else $error("drained entry with error status");

    // payload of a non-entry result is zero
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !entry_valid |-> entry_handle == '0 && entry_argument == '0)
        else $error("non-entry result carries payload");

    // a full queue result (its drop count just moved) carries no entry and is marked last
    a_full_counts: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == dcq_pkg::ST_FULL |-> !entry_valid && last)
        else $error("queue-full result malformed");

endmodule
